// ===== hw/rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: register indexes
// of the control port and the one-hot sequencer states.
// ----------------------------------------------------------------------------
package skf_pkg;

   // control register port
   localparam int CSR_INDEX_WIDTH = 2;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_PROCESS_NOISE = 2'd0;
   localparam csr_index_type CSR_MEASURE_NOISE = 2'd1;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

endpackage

// ===== hw/rtl/skf_if.sv =====
// ----------------------------------------------------------------------------
// skf_if
// Valid/ready channels of the scalar Kalman filter: sample input, estimate
// output and the control register write channel.
// ----------------------------------------------------------------------------

// sample channel
interface skf_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// estimate channel
interface skf_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] estimate;

   modport source (output valid, output estimate, input ready);
   modport sink   (input valid, input estimate, output ready);
endinterface

// control register write channel
interface skf_csr_if #(parameter int DATA_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [skf_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]         wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Bit-serial restoring divider for the gain: quot = floor(num * 2^F / den),
// one quotient bit per cycle. A zero denominator gives zero, and num >= den
// saturates to all ones.
// ----------------------------------------------------------------------------
module skf_div #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] num,
   input  logic [DATA_WIDTH:0]   den,
   output logic                  done,
   output logic [FRAC_BITS-1:0]  quot
);

   localparam int CW = $clog2(FRAC_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH:0]   rem_ff, rem_in;
   logic [DATA_WIDTH:0]   den_ff, den_in;
   logic [FRAC_BITS-1:0]  q_ff, q_in;
   logic                  zero_ff, zero_in;
   logic                  sat_ff, sat_in;

   logic [DATA_WIDTH+1:0] rem2;
   logic [DATA_WIDTH+1:0] rem_sub;
   logic                  fits;
   logic                  last;

   // one restoring step
   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, den_ff};
   assign fits    = rem2 >= {1'b0, den_ff};
   assign last    = cnt_ff == CW'(FRAC_BITS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
         q_in    = '0;
         zero_in = den == '0;
         sat_in  = {1'b0, num} >= den;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DATA_WIDTH:0] : rem2[DATA_WIDTH:0];
         q_in   = {q_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
   end

   assign done = done_ff;
   assign quot = zero_ff ? '0 : (sat_ff ? '1 : q_ff);

endmodule

// ===== hw/rtl/skf_mul.sv =====
// ----------------------------------------------------------------------------
// skf_mul
// Bit-serial shift-add multiplier: prod = floor(mcand * mplier / 2^F), one
// multiplier bit per cycle, LSB first. inexact flags a nonzero dropped part.
// ----------------------------------------------------------------------------
module skf_mul #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] mcand,
   input  logic [FRAC_BITS-1:0]  mplier,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] prod,
   output logic                  inexact
);

   localparam int CW = $clog2(FRAC_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [FRAC_BITS-1:0]  b_ff, b_in;
   logic                  sticky_ff, sticky_in;

   logic [DATA_WIDTH:0]   sum;
   logic                  last;

   // add the partial product, then halve
   assign sum  = {1'b0, acc_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);
   assign last = cnt_ff == CW'(FRAC_BITS - 1);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      sticky_in = sticky_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         a_in      = mcand;
         b_in      = mplier;
         sticky_in = 1'b0;
      end else if (busy_ff) begin
         acc_in    = sum[DATA_WIDTH:1];
         sticky_in = sticky_ff | sum[0];
         b_in      = b_ff >> 1;
         cnt_in    = cnt_ff + CW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      sticky_ff <= sticky_in;
   end

   assign done    = done_ff;
   assign prod    = acc_ff;
   assign inexact = sticky_ff;

endmodule

// ===== hw/rtl/scalar_kalman_filter.sv =====
// A sample is taken only in the idle state, so a new one is accepted only after
// the previous estimate has been loaded into the output register. Each sample
// passes through the bit-serial gain divider and then the bit-serial
// multipliers, one bit per cycle each.
// A finished estimate waits in the output register while the next runs.
// Reset (synchronous, active high) clears estimate, covariance and noise regs.
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// First-order scalar Kalman filter in fixed point: covariance predict with
// saturation, gain P/(P+R) by a serial divider, estimate and covariance
// update by two serial multipliers.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   skf_req_if.sink  req_bus,
   skf_rsp_if.source rsp_bus,
   skf_csr_if.sink  csr_bus
);

   localparam int W = DATA_WIDTH;

   skf_pkg::state_type state_ff, state_in;

   logic [W-1:0]   q_ff, q_in;
   logic [W-1:0]   r_ff, r_in;
   logic [W-1:0]   x_ff, x_in;
   logic [W-1:0]   p_ff, p_in;
   logic [W-1:0]   pm_ff, pm_in;
   logic [W:0]     diff_ff, diff_in;
   logic [W-1:0]   mag_ff, mag_in;
   logic           neg_ff, neg_in;
   logic           out_valid_ff, out_valid_in;
   logic [W-1:0]   out_est_ff, out_est_in;

   logic           req_take;
   logic           out_load;
   logic [W:0]     sum_pq;
   logic [W:0]     den;
   logic [W:0]     neg_diff;
   logic           div_start;
   logic           div_done;
   logic [FRAC_BITS-1:0] gain;
   logic           mul_start;
   logic           mstep_done, mcov_done;
   logic [W-1:0]   step, cstep;
   logic           step_inx, cstep_inx;
   logic [W-1:0]   x_next, p_next;

   // handshakes
   assign req_take      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = state_ff == skf_pkg::ST_IDLE;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.estimate = out_est_ff;
   assign out_load = (state_ff == skf_pkg::ST_FIN) && (!out_valid_ff || rsp_bus.ready);

   // predict: covariance plus process noise, saturating; innovation
   assign sum_pq  = {1'b0, p_ff} + {1'b0, q_ff};
   assign diff_in = {req_bus.sample[W-1], req_bus.sample} - {x_ff[W-1], x_ff};

   // gain denominator and innovation magnitude
   assign den      = {1'b0, pm_ff} + {1'b0, r_ff};
   assign neg_diff = (W+1)'(0) - diff_ff;

   assign div_start = state_ff == skf_pkg::ST_PREP;
   assign mul_start = (state_ff == skf_pkg::ST_DIV) && div_done;

   // update: floor on the negative side adds one when bits were dropped
   assign x_next = neg_ff ? (x_ff - step - W'(step_inx)) : (x_ff + step);
   assign p_next = pm_ff - cstep - W'(cstep_inx);

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      pm_in        = pm_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff;
      out_est_in   = out_est_ff;

      // register writes
      if (csr_bus.valid) begin
         case (csr_bus.index)
            skf_pkg::CSR_PROCESS_NOISE: q_in = csr_bus.wdata;
            skf_pkg::CSR_MEASURE_NOISE: r_in = csr_bus.wdata;
            default: ;
         endcase
      end

      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         skf_pkg::ST_IDLE: begin
            if (req_take) begin
               pm_in    = sum_pq[W] ? '1 : sum_pq[W-1:0];
               state_in = skf_pkg::ST_PREP;
            end
         end
         skf_pkg::ST_PREP: begin
            neg_in   = diff_ff[W];
            mag_in   = diff_ff[W] ? neg_diff[W-1:0] : diff_ff[W-1:0];
            state_in = skf_pkg::ST_DIV;
         end
         skf_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = skf_pkg::ST_MUL;
            end
         end
         skf_pkg::ST_MUL: begin
            if (mstep_done) begin
               state_in = skf_pkg::ST_FIN;
            end
         end
         skf_pkg::ST_FIN: begin
            if (out_load) begin
               x_in         = x_next;
               p_in         = p_next;
               out_valid_in = 1'b1;
               out_est_in   = x_next;
               state_in     = skf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::ST_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::ST_IDLE;
         q_ff         <= '0;
         r_ff         <= '0;
         x_ff         <= '0;
         p_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // per-transaction datapath
   always_ff @(posedge clock) begin
      pm_ff      <= pm_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      out_est_ff <= out_est_in;
      if (req_take) begin
         diff_ff <= diff_in;
      end
   end

   // gain = Pm / (Pm + R) in Q0.F
   skf_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pm_ff),
      .den   (den),
      .done  (div_done),
      .quot  (gain)
   );

   // estimate step = gain * |z - x|
   skf_mul #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mul_step (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mag_ff),
      .mplier  (gain),
      .done    (mstep_done),
      .prod    (step),
      .inexact (step_inx)
   );

   // covariance reduction = gain * Pm
   skf_mul #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mul_cov (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (pm_ff),
      .mplier  (gain),
      .done    (mcov_done),
      .prod    (cstep),
      .inexact (cstep_inx)
   );

   // checks
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == skf_pkg::ST_DIV)
      else $error("divider finished outside its phase");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mstep_done |-> state_ff == skf_pkg::ST_MUL)
      else $error("multiplier finished outside its phase");

   a_mul_in_lockstep: assert property (@(posedge clock) disable iff (reset)
      mstep_done == mcov_done)
      else $error("multipliers out of step");

   a_fin_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::ST_FIN) && (!out_valid_ff || rsp_bus.ready)
      |=> rsp_bus.valid && (state_ff == skf_pkg::ST_IDLE))
      else $error("finished transaction not delivered");

endmodule

// ===== sim/scalar_kalman_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_test
// Self-checking bench for the scalar Kalman filter. A bit-exact predictor
// tracks estimate and covariance for every sample transaction. A checker
// compares each estimate transaction with the oldest prediction. Directed
// corner cases come first. Random phases follow, each with its own noise
// settings, sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_test;

   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int HALF_PERIOD    = 10;
   localparam int SETTLE_CYCLES  = 2 * FRAC_BITS + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 230;

   // register indexes past the implemented ones
   localparam skf_pkg::csr_index_type CSR_SPARE_A = 2'd2;
   localparam skf_pkg::csr_index_type CSR_SPARE_B = 2'd3;

   localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic [DATA_WIDTH-1:0]        NOISE_MAX  = 32'hFFFF_FFFF;

   typedef enum {SMP_FULL, SMP_TRACK, SMP_EXTREME} sample_kind_type;
   typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skf_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_bus ();
   skf_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_bus ();
   skf_csr_if #(.DATA_WIDTH(DATA_WIDTH)) csr_bus ();

   scalar_kalman_filter #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state and its copy of the noise registers
   logic signed [DATA_WIDTH-1:0] filt_estimate   = '0;
   logic [DATA_WIDTH-1:0]        filt_covariance = '0;
   logic [DATA_WIDTH-1:0]        proc_noise      = '0;
   logic [DATA_WIDTH-1:0]        meas_noise      = '0;

   logic signed [DATA_WIDTH-1:0] estimate_queue[$];
   logic signed [DATA_WIDTH-1:0] expected_estimate;
   int                           mismatch_count = 0;

   // sender and receiver pacing
   int             gap_limit   = 0;
   int             burst_limit = 1;
   ready_mode_type ready_mode  = READY_ALWAYS;
   int             hold_serial = 0;
   int             hold_seen   = 0;
   int             hold_left   = 0;
   int             ready_phase = 0;
   int             idle_cycles = 0;
   logic signed [DATA_WIDTH-1:0] track_level = '0;

   // one filter step: covariance predict, gain, estimate and covariance update
   function automatic logic signed [DATA_WIDTH-1:0] kalman_update(
      input logic signed [DATA_WIDTH-1:0] z
   );
      logic [63:0] p_pred;
      logic [63:0] denom;
      logic [63:0] gain;
      logic [63:0] cov_prod;
      longint      delta;
      longint      step_prod;
      longint      next_est;
      p_pred = 64'(filt_covariance) + 64'(proc_noise);
      if (p_pred > 64'(NOISE_MAX)) begin
         p_pred = 64'(NOISE_MAX);
      end
      denom = p_pred + 64'(meas_noise);
      // zero denominator gives zero gain; unit gain saturates just below one
      if (denom == 0) begin
         gain = 0;
      end else if (p_pred >= denom) begin
         gain = (64'd1 << FRAC_BITS) - 1;
      end else begin
         gain = (p_pred << FRAC_BITS) / denom;
      end
      // floor of the signed product, so a negative step rounds away from x
      delta     = longint'(z) - longint'(filt_estimate);
      step_prod = delta * longint'(gain);
      next_est  = longint'(filt_estimate) + (step_prod >>> FRAC_BITS);
      cov_prod  = ((64'd1 << FRAC_BITS) - gain) * p_pred;
      filt_covariance = cov_prod[FRAC_BITS +: DATA_WIDTH];
      filt_estimate   = next_est[DATA_WIDTH-1:0];
      return filt_estimate;
   endfunction

   // sample source: tracking signal with noise, full-range noise, extremes
   function automatic logic signed [DATA_WIDTH-1:0] next_sample(input sample_kind_type kind);
      logic signed [DATA_WIDTH-1:0] value;
      value = '0;
      case (kind)
         SMP_FULL: begin
            value = $urandom;
         end
         SMP_TRACK: begin
            if ($urandom_range(0, 63) == 0) begin
               track_level = $urandom;
            end
            track_level = track_level + $urandom_range(0, 'h2000) - 'h1000;
            value = track_level + $urandom_range(0, 'h40000) - 'h20000;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: value = SAMPLE_MAX;
               1: value = SAMPLE_MIN;
               2: value = 0;
               3: value = -1;
               default: value = 1;
            endcase
         end
      endcase
      return value;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_noise();
      logic [DATA_WIDTH-1:0] value;
      case ($urandom_range(0, 5))
         0: value = 0;
         1: value = NOISE_MAX;
         2: value = $urandom_range(1, 'h100);
         3: value = $urandom_range('h100, 'h10_0000);
         4: value = $urandom_range('h10_0000, 'h1000_0000);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   // one sample transaction; valid stays high for a following sample
   task automatic send_sample(input logic signed [DATA_WIDTH-1:0] value);
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      estimate_queue.push_back(kalman_update(value));
   endtask

   // one register write transaction; csr_release drops valid afterwards
   task automatic csr_write(input skf_pkg::csr_index_type index,
                            input logic [DATA_WIDTH-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= data;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      case (index)
         skf_pkg::CSR_PROCESS_NOISE: proc_noise = data;
         skf_pkg::CSR_MEASURE_NOISE: meas_noise = data;
         default: ;
      endcase
   endtask

   task automatic csr_release();
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (estimate_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // block idle: all estimates back plus one processing time
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_noise(input logic [DATA_WIDTH-1:0] q, input logic [DATA_WIDTH-1:0] r);
      settle();
      csr_write(skf_pkg::CSR_PROCESS_NOISE, q);
      csr_write(skf_pkg::CSR_MEASURE_NOISE, r);
      csr_release();
   endtask

   // bursts of random length with random gaps; mostly tracking samples
   task automatic run_samples(input int count);
      int              sent;
      int              burst;
      int              gap;
      int              pick;
      sample_kind_type kind;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, burst_limit);
         for (int i = 0; i < burst && sent < count; i++) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? SMP_TRACK : (pick < 9) ? SMP_FULL : SMP_EXTREME;
            send_sample(next_sample(kind));
            sent++;
         end
         gap = (gap_limit > 0) ? $urandom_range(0, gap_limit) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // reset state with zero noise: denominator is zero, estimate stays put
   task automatic test_zero_denominator();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
   endtask

   // R = 0 with P > 0: gain saturates just below one
   task automatic test_unit_gain();
      set_noise(1, 0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-1);
      send_sample(1);
   endtask

   // P + Q overflows and clamps
   task automatic test_covariance_saturation();
      set_noise(NOISE_MAX, 1);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(0);
      set_noise(NOISE_MAX, NOISE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
   endtask

   // writes past the register list must leave the noise settings alone
   task automatic test_unused_register();
      settle();
      csr_write(CSR_SPARE_A, $urandom);
      csr_write(CSR_SPARE_B, $urandom);
      csr_release();
      send_sample(SAMPLE_MIN);
      send_sample(12345);
      send_sample(SAMPLE_MAX);
   endtask

   // large R with zero process noise: the gain stays at or below one half
   task automatic test_small_gain();
      set_noise(0, NOISE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-1);
   endtask

   // long receiver hold-off while the sender keeps offering samples
   task automatic test_backpressure();
      set_noise($urandom_range('h100, 'h1_0000), $urandom_range('h1_0000, 'h100_0000));
      ready_mode  = READY_ALWAYS;
      gap_limit   = 0;
      burst_limit = 30;
      hold_serial = hold_serial + 1;
      run_samples(30);
   endtask

   // sender pauses until every estimate has come back, then resumes
   task automatic test_drain_pause();
      ready_mode  = READY_RANDOM;
      gap_limit   = 20;
      burst_limit = 8;
      run_samples(40);
      wait_drained();
      run_samples(40);
   endtask

   // random noise settings and pacing per phase; first phase runs flat out
   task automatic test_random_phases();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_noise(pick_noise(), pick_noise());
         if (phase == 0) begin
            ready_mode  = READY_ALWAYS;
            gap_limit   = 0;
            burst_limit = 1;
         end else begin
            case ($urandom_range(0, 2))
               0: ready_mode = READY_ALWAYS;
               1: ready_mode = READY_RANDOM;
               default: ready_mode = READY_PERIODIC;
            endcase
            case ($urandom_range(0, 2))
               0: gap_limit = 0;
               1: gap_limit = 10;
               default: gap_limit = 100;
            endcase
            burst_limit = $urandom_range(1, 16);
         end
         run_samples(PHASE_ITEMS);
      end
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= skf_pkg::CSR_PROCESS_NOISE;
      csr_bus.wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_denominator();
      test_unit_gain();
      test_covariance_saturation();
      test_unused_register();
      test_small_gain();
      test_backpressure();
      test_drain_pause();
      test_random_phases();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && estimate_queue.size() == 0) begin
         $display("scalar_kalman_filter regression: pass");
      end else begin
         $display("scalar_kalman_filter regression: fail");
      end
      $finish;
   end

   // receiver: hold-off on request, otherwise the selected stall pattern
   initial rsp_bus.ready = 1'b0;
   always @(posedge clock) begin
      ready_phase = ready_phase + 1;
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = HOLDOFF_CYCLES;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS:   rsp_bus.ready <= 1'b1;
            READY_RANDOM:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default:        rsp_bus.ready <= ((ready_phase % 61) >= 45);
         endcase
      end
   end

   // estimate checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (estimate_queue.size() == 0) begin
            $display("%0t: estimate with none pending: expected none, actual %h",
                     $time, rsp_bus.estimate);
            mismatch_count = mismatch_count + 1;
         end else begin
            expected_estimate = estimate_queue.pop_front();
            if (rsp_bus.estimate !== expected_estimate) begin
               $display("%0t: estimate mismatch: expected %h, actual %h",
                        $time, expected_estimate, rsp_bus.estimate);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("scalar_kalman_filter regression: fail");
         $finish;
      end
   end

endmodule
